@@ hw/rtl/scsg_pkg.sv @@
// scsg_pkg: shared types, command codes and the move length table
// of the stepper command step generator; no dependencies
`timescale 1ns / 1ps

package scsg_pkg;

  localparam logic [7:0] CODE_REPORT   = 8'h02;
  localparam logic [3:0] HI_FORWARD    = 4'h1;
  localparam logic [3:0] HI_REVERSE    = 4'h2;
  localparam logic [3:0] LO_LAST_MOVE  = 4'h5;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd2000;
  localparam int unsigned HALF_STEPS_WIDTH  = 12;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned REG_HALF_PERIOD = 0;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_REPORT = 2'd1,
    CMD_MOVE   = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic       dir;
    logic [2:0] sel;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    cmd_t cmd;
  } item_t;

  // twice the step count of each move code
  function automatic logic [HALF_STEPS_WIDTH-1:0] half_steps(input logic [2:0] sel);
    logic [HALF_STEPS_WIDTH-1:0] n;
    n = '0;
    case (sel)
      3'd0:    n = 12'd2;
      3'd1:    n = 12'd20;
      3'd2:    n = 12'd200;
      3'd3:    n = 12'd400;
      3'd4:    n = 12'd2000;
      3'd5:    n = 12'd4000;
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

@@ hw/rtl/scsg_front.sv @@
// scsg_front: accepts input words and classifies command bytes
// depends on scsg_pkg
`timescale 1ns / 1ps

module scsg_front import scsg_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] rx_byte_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output item_t      q_item_o
);

  logic [3:0] hi;
  logic [3:0] lo;
  cmd_t       cmd;

  assign hi = rx_byte_i[7:4];
  assign lo = rx_byte_i[3:0];

  always_comb begin
    cmd.kind = CMD_NONE;
    cmd.dir  = 1'b0;
    cmd.sel  = lo[2:0];
    if (rx_byte_i == CODE_REPORT) begin
      cmd.kind = CMD_REPORT;
    end else if ((hi == HI_FORWARD || hi == HI_REVERSE) && lo <= LO_LAST_MOVE) begin
      cmd.kind = CMD_MOVE;
      cmd.dir  = (hi == HI_REVERSE);
    end
  end

  assign in_ready_o       = !q_full_i;
  assign q_push_o         = in_valid_i && !q_full_i;
  assign q_item_o.is_tick = op_i;
  assign q_item_o.cmd     = cmd;

endmodule

@@ hw/rtl/scsg_queue.sv @@
// scsg_queue: short register queue between the front and back parts
// depends on scsg_pkg
`timescale 1ns / 1ps

module scsg_queue import scsg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t                  mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  logic                   do_push;
  logic                   do_pop;

  assign full_o  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [QUEUE_PTR_W-1:0] bump(input logic [QUEUE_PTR_W-1:0] p);
    return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? bump(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? bump(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ hw/rtl/scsg_back.sv @@
// scsg_back: executes queued words, runs the step timing and position
// counter and holds the result register; depends on scsg_pkg
`timescale 1ns / 1ps

module scsg_back import scsg_pkg::*; #(
  parameter int unsigned POSITION_WIDTH = 32,
  parameter int unsigned DELAY_WIDTH    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] half_period_i,
  input  logic        q_valid_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        step_pin_o,
  output logic        dir_pin_o,
  output logic        moving_o,
  output logic        report_valid_o,
  output logic [7:0]  report_byte_o
);

  logic                        busy_q, busy_d;
  logic [HALF_STEPS_WIDTH-1:0] hs_q, hs_d;
  logic [DELAY_WIDTH-1:0]      delay_q, delay_d;
  logic                        step_q, step_d;
  logic                        dir_q, dir_d;
  logic [POSITION_WIDTH-1:0]   pos_q, pos_d;
  logic                        pend_valid_q, pend_valid_d;
  cmd_t                        pend_q, pend_d;
  logic                        out_valid_q;
  logic                        step_out_q, dir_out_q, moving_q, rep_valid_q;
  logic [7:0]                  rep_byte_q;

  logic [DELAY_WIDTH+15:0]     period_ext;
  logic [DELAY_WIDTH-1:0]      period_load;
  logic [DELAY_WIDTH-1:0]      delay_dec;
  logic                        exec_go;
  cmd_t                        exec_cmd;
  logic                        report;
  logic                        advance;

  assign period_ext  = {{DELAY_WIDTH{1'b0}}, half_period_i};
  assign period_load = (period_ext[DELAY_WIDTH-1:0] == '0) ? DELAY_WIDTH'(1)
                                                            : period_ext[DELAY_WIDTH-1:0];
  assign delay_dec   = delay_q - 1'b1;

  assign advance = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = advance;

  always_comb begin
    busy_d       = busy_q;
    hs_d         = hs_q;
    delay_d      = delay_q;
    step_d       = step_q;
    dir_d        = dir_q;
    pos_d        = pos_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    exec_go      = 1'b0;
    exec_cmd     = q_item_i.cmd;
    report       = 1'b0;

    if (!q_item_i.is_tick) begin
      if (!busy_q) begin
        exec_go = 1'b1;
      end else if (!pend_valid_q) begin
        pend_valid_d = 1'b1;
        pend_d       = q_item_i.cmd;
      end
    end else if (busy_q) begin
      delay_d = delay_dec;
      if (delay_dec == '0) begin
        if (!step_q) begin
          pos_d  = dir_q ? pos_q - 1'b1 : pos_q + 1'b1;
          report = 1'b1;
        end
        if (hs_q != '0) begin
          hs_d = hs_q - 1'b1;
        end
        if (pend_valid_q) begin
          busy_d       = 1'b0;
          hs_d         = '0;
          step_d       = 1'b0;
          pend_valid_d = 1'b0;
          exec_go      = 1'b1;
          exec_cmd     = pend_q;
        end else if (hs_d == '0) begin
          busy_d = 1'b0;
          step_d = 1'b0;
        end else begin
          step_d  = !step_q;
          delay_d = period_load;
        end
      end
    end

    if (exec_go) begin
      if (exec_cmd.kind == CMD_REPORT) begin
        report = 1'b1;
      end else if (exec_cmd.kind == CMD_MOVE) begin
        dir_d   = exec_cmd.dir;
        hs_d    = half_steps(exec_cmd.sel);
        busy_d  = 1'b1;
        step_d  = 1'b1;
        delay_d = period_load;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      hs_q         <= '0;
      delay_q      <= '0;
      step_q       <= 1'b0;
      dir_q        <= 1'b0;
      pos_q        <= '0;
      pend_valid_q <= 1'b0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (advance) begin
        busy_q       <= busy_d;
        hs_q         <= hs_d;
        delay_q      <= delay_d;
        step_q       <= step_d;
        dir_q        <= dir_d;
        pos_q        <= pos_d;
        pend_valid_q <= pend_valid_d;
        pend_q       <= pend_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      step_out_q  <= step_d;
      dir_out_q   <= dir_d;
      moving_q    <= busy_d;
      rep_valid_q <= report;
      rep_byte_q  <= report ? pos_d[7:0] : 8'h00;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign step_pin_o     = step_out_q;
  assign dir_pin_o      = dir_out_q;
  assign moving_o       = moving_q;
  assign report_valid_o = rep_valid_q;
  assign report_byte_o  = rep_byte_q;

endmodule

@@ hw/rtl/stepper_command_step_generator_top.sv @@
// stepper_command_step_generator_top: APB register, front decoder, queue
// and back executor; depends on scsg_pkg, scsg_front, scsg_queue, scsg_back
//
// Usage: each input word is either a command byte (op_i = 0, rx_byte_i) or
// one microsecond tick (op_i = 1), moved on in_valid_i / in_ready_o. Every
// accepted word gives exactly one result word on out_valid_o / out_ready_i
// with the step and direction levels, the moving flag and an optional
// position report byte. With the queue empty an accepted word is first
// written into the queue and then executed into the result register, which
// offers it on out_valid_o; throughput is one word per cycle while results
// are taken, set by the update of the back executor's counters. If the
// receiver stalls, the result register holds and the two-entry queue fills,
// after which in_ready_o drops until results are taken again. The half
// period register (ticks per step half period, zero acts as one) sits at APB
// address 0 and should be written only while idle. Reset clears the motion
// state, position and held command (not the output pin registers) and sets
// the half period to 2000 ticks; in_ready_o is high straight out of reset.
`timescale 1ns / 1ps

module stepper_command_step_generator_top import scsg_pkg::*; #(
  parameter int unsigned POSITION_WIDTH = 32,
  parameter int unsigned DELAY_WIDTH    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        step_pin_o,
  output logic        dir_pin_o,
  output logic        moving_o,
  output logic        report_valid_o,
  output logic [7:0]  report_byte_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] half_period_q;
  logic        reg_sel;
  logic        q_full;
  logic        q_push;
  item_t       q_in;
  logic        q_pop;
  logic        q_valid;
  item_t       q_out;

  assign reg_sel = (paddr[2] == 1'(REG_HALF_PERIOD));
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {16'h0000, half_period_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HALF_PERIOD_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      half_period_q <= pwdata[15:0];
    end
  end

  scsg_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_in)
  );

  scsg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  scsg_back #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .DELAY_WIDTH    (DELAY_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .half_period_i  (half_period_q),
    .q_valid_i      (q_valid),
    .q_item_i       (q_out),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .step_pin_o     (step_pin_o),
    .dir_pin_o      (dir_pin_o),
    .moving_o       (moving_o),
    .report_valid_o (report_valid_o),
    .report_byte_o  (report_byte_o)
  );

endmodule
